// ----- rtl/tts_pkg.sv -----
// shared types and constants for the text terminal screen engine
// no dependencies
`default_nettype none

package tts_pkg;

    // default grid geometry
    localparam int ROWS_DEF       = 25;
    localparam int COLS_DEF       = 80;
    localparam int TAB_SPACES_DEF = 4;

    // fixed field widths
    localparam int KIND_W      = 3;
    localparam int CHAR_W      = 8;
    localparam int ROW_IN_W    = 5;
    localparam int COL_IN_W    = 7;
    localparam int COLOR_W     = 4;
    localparam int INDEX_W     = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_FG = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_BG = 2'd1;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h00;

    // colors after reset
    localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHAR_W-1:0]   char_code;
        logic [ROW_IN_W-1:0] row;
        logic [COL_IN_W-1:0] col;
        logic [COLOR_W-1:0]  fg_color;
        logic [COLOR_W-1:0]  bg_color;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cursor_index;
        logic [CHAR_W-1:0]  cell_char;
        logic [COLOR_W-1:0] cell_fg;
        logic [COLOR_W-1:0] cell_bg;
    } out_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [CHAR_W-1:0]  ch;
    } cell_t;

    typedef enum logic [2:0] {
        WR_NONE      = 3'd0,
        WR_CUR_CHAR  = 3'd1,
        WR_CUR_BLANK = 3'd2,
        WR_ITEM      = 3'd3,
        WR_FILL      = 3'd4,
        WR_SCROLL    = 3'd5
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_ITEM   = 2'd1,
        RD_SCROLL = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD    = 3'd0,
        CUR_ADVANCE = 3'd1,
        CUR_NEWLINE = 3'd2,
        CUR_BACK    = 3'd3,
        CUR_MOVE    = 3'd4,
        CUR_HOME    = 3'd5
    } cur_op_t;

    typedef struct packed {
        logic    load;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        cur_op_t cur_op;
        logic    fill_reset_colors;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    tab_init;
        logic    tab_dec;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_newline;
        logic              is_backspace;
        logic              at_last_col;
        logic              at_last_row;
        logic              fill_last;
        logic              scroll_last;
        logic              tab_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tts_ctrl.sv -----
// sequencer for the text terminal screen engine
// depends on tts_pkg
`default_nettype none

module tts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tts_pkg::dp_stat_t stat,
    output logic                  busy,
    output tts_pkg::dp_cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INIT     = 8'b0000_0010,
        S_DISPATCH = 8'b0000_0100,
        S_PUT      = 8'b0000_1000,
        S_BS2      = 8'b0001_0000,
        S_SCROLL   = 8'b0010_0000,
        S_CLEAR    = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next            = state_reg;
        busy                  = 1'b1;
        cmd.load              = 1'b0;
        cmd.wr_sel            = tts_pkg::WR_NONE;
        cmd.rd_sel            = tts_pkg::RD_NONE;
        cmd.cur_op            = tts_pkg::CUR_HOLD;
        cmd.fill_reset_colors = 1'b0;
        cmd.cnt_clr           = 1'b0;
        cmd.cnt_inc           = 1'b0;
        cmd.tab_init          = 1'b0;
        cmd.tab_dec           = 1'b0;
        cmd.finish            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_INIT:
            begin
                cmd.wr_sel            = tts_pkg::WR_FILL;
                cmd.fill_reset_colors = 1'b1;
                cmd.cnt_inc           = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_DISPATCH:
            begin
                case (stat.kind)
                    tts_pkg::KIND_PUT:
                    begin
                        cmd.tab_init = 1'b1;
                        if (stat.is_newline)
                        begin
                            cmd.cur_op = tts_pkg::CUR_NEWLINE;
                            if (stat.at_last_row)
                            begin
                                cmd.cnt_clr = 1'b1;
                                state_next  = S_SCROLL;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        else if (stat.is_backspace)
                        begin
                            cmd.wr_sel = tts_pkg::WR_CUR_BLANK;
                            cmd.cur_op = tts_pkg::CUR_BACK;
                            state_next = S_BS2;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    tts_pkg::KIND_WRITE:
                    begin
                        cmd.wr_sel = tts_pkg::WR_ITEM;
                        state_next = S_FINISH;
                    end
                    tts_pkg::KIND_MOVE:
                    begin
                        cmd.cur_op = tts_pkg::CUR_MOVE;
                        state_next = S_FINISH;
                    end
                    tts_pkg::KIND_CLEAR:
                    begin
                        cmd.cur_op  = tts_pkg::CUR_HOME;
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_CLEAR;
                    end
                    tts_pkg::KIND_READ:
                    begin
                        cmd.rd_sel = tts_pkg::RD_ITEM;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_PUT:
            begin
                cmd.wr_sel = tts_pkg::WR_CUR_CHAR;
                if (!stat.at_last_col)
                begin
                    cmd.cur_op = tts_pkg::CUR_ADVANCE;
                end
                else
                begin
                    cmd.cur_op = tts_pkg::CUR_NEWLINE;
                end

                if (stat.at_last_col && stat.at_last_row)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_SCROLL;
                end
                else if (stat.tab_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.tab_dec = 1'b1;
                end
            end

            S_BS2:
            begin
                cmd.wr_sel = tts_pkg::WR_CUR_BLANK;
                state_next = S_FINISH;
            end

            S_SCROLL:
            begin
                cmd.wr_sel  = tts_pkg::WR_SCROLL;
                cmd.rd_sel  = tts_pkg::RD_SCROLL;
                cmd.cnt_inc = 1'b1;
                if (stat.scroll_last)
                begin
                    if (stat.tab_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.tab_dec = 1'b1;
                        state_next  = S_PUT;
                    end
                end
            end

            S_CLEAR:
            begin
                cmd.wr_sel  = tts_pkg::WR_FILL;
                cmd.cnt_inc = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tts_dp.sv -----
// datapath of the text terminal screen engine: cell memory, cursor, counters
// depends on tts_pkg
`default_nettype none

module tts_dp #(
    parameter int ROWS       = tts_pkg::ROWS_DEF,
    parameter int COLS       = tts_pkg::COLS_DEF,
    parameter int TAB_SPACES = tts_pkg::TAB_SPACES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tts_pkg::in_item_t                 item,
    input  wire logic                              cfg_valid,
    input  wire logic [tts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire tts_pkg::dp_cmd_t                  cmd,
    output tts_pkg::dp_stat_t                      stat,
    output logic                                   done,
    output tts_pkg::out_item_t                     result
);

    localparam int NCELLS     = ROWS * COLS;
    localparam int SCROLL_LEN = NCELLS - COLS;
    localparam int ADDR_W     = $clog2(NCELLS);
    localparam int CNT_W      = $clog2(NCELLS + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);
    localparam int TAB_W      = $clog2(TAB_SPACES + 1);
    localparam int IDX_W      = tts_pkg::INDEX_W;

    tts_pkg::in_item_t  item_reg;
    tts_pkg::out_item_t result_reg;
    tts_pkg::cell_t     rd_data_reg;
    tts_pkg::cell_t     mem [NCELLS];

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TAB_W-1:0] tab_reg, tab_next;
    logic             done_reg;
    logic [tts_pkg::COLOR_W-1:0] fg_reg, bg_reg;

    logic [ADDR_W-1:0] cur_addr, item_addr, waddr, raddr;
    logic              item_ok, we, re, is_tab, read_hit;
    logic [ROW_W-1:0]  row_sat;
    logic [COL_W-1:0]  col_sat;
    tts_pkg::cell_t    blank, wdata;
    logic [tts_pkg::CHAR_W-1:0] put_code;

    assign cur_addr  = ADDR_W'(row_reg) * ADDR_W'(COLS) + ADDR_W'(col_reg);
    assign item_addr = ADDR_W'(item_reg.row) * ADDR_W'(COLS) + ADDR_W'(item_reg.col);
    assign item_ok   = (32'(item_reg.row) < 32'(ROWS)) && (32'(item_reg.col) < 32'(COLS));
    assign row_sat   = (32'(item_reg.row) < 32'(ROWS)) ? ROW_W'(item_reg.row)
                                                       : ROW_W'(ROWS - 1);
    assign col_sat   = (32'(item_reg.col) < 32'(COLS)) ? COL_W'(item_reg.col)
                                                       : COL_W'(COLS - 1);
    assign is_tab    = (item_reg.char_code == tts_pkg::CH_TAB);
    assign put_code  = is_tab ? tts_pkg::CH_SPACE : item_reg.char_code;
    assign blank     = '{bg: bg_reg, fg: fg_reg, ch: tts_pkg::CH_BLANK};
    assign read_hit  = (item_reg.kind == tts_pkg::KIND_READ) && item_ok;

    // status toward the sequencer
    assign stat.kind         = item_reg.kind;
    assign stat.is_newline   = (item_reg.char_code == tts_pkg::CH_NEWLINE);
    assign stat.is_backspace = (item_reg.char_code == tts_pkg::CH_BACKSPACE);
    assign stat.at_last_col  = (col_reg == COL_W'(COLS - 1));
    assign stat.at_last_row  = (row_reg == ROW_W'(ROWS - 1));
    assign stat.fill_last    = (cnt_reg == CNT_W'(NCELLS - 1));
    assign stat.scroll_last  = (cnt_reg == CNT_W'(NCELLS));
    assign stat.tab_last     = (tab_reg == TAB_W'(1));

    // memory write port
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_addr;
        wdata = blank;
        case (cmd.wr_sel)
            tts_pkg::WR_CUR_CHAR:
            begin
                we    = 1'b1;
                wdata = '{bg: bg_reg, fg: fg_reg, ch: put_code};
            end
            tts_pkg::WR_CUR_BLANK:
            begin
                we = 1'b1;
            end
            tts_pkg::WR_ITEM:
            begin
                we    = item_ok;
                waddr = item_addr;
                wdata = '{bg: item_reg.bg_color, fg: item_reg.fg_color,
                          ch: item_reg.char_code};
            end
            tts_pkg::WR_FILL:
            begin
                we    = 1'b1;
                waddr = cnt_reg[ADDR_W-1:0];
                if (cmd.fill_reset_colors)
                begin
                    wdata = '{bg: tts_pkg::RESET_BG, fg: tts_pkg::RESET_FG,
                              ch: tts_pkg::CH_BLANK};
                end
            end
            tts_pkg::WR_SCROLL:
            begin
                // write trails the read by one cell; last row gets blanks
                we    = (cnt_reg != '0);
                waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                if (cnt_reg <= CNT_W'(SCROLL_LEN))
                begin
                    wdata = rd_data_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // memory read port
    always_comb
    begin
        re    = 1'b0;
        raddr = item_addr;
        case (cmd.rd_sel)
            tts_pkg::RD_ITEM:
            begin
                re = item_ok;
            end
            tts_pkg::RD_SCROLL:
            begin
                re    = (cnt_reg < CNT_W'(SCROLL_LEN));
                raddr = ADDR_W'(cnt_reg + CNT_W'(COLS));
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // cursor
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            tts_pkg::CUR_ADVANCE:
            begin
                col_next = col_reg + COL_W'(1);
            end
            tts_pkg::CUR_NEWLINE:
            begin
                col_next = '0;
                if (!stat.at_last_row)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            tts_pkg::CUR_BACK:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            tts_pkg::CUR_MOVE:
            begin
                row_next = row_sat;
                col_next = col_sat;
            end
            tts_pkg::CUR_HOME:
            begin
                row_next = '0;
                col_next = '0;
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // sweep and tab counters
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        tab_next = tab_reg;
        if (cmd.tab_init)
        begin
            tab_next = is_tab ? TAB_W'(TAB_SPACES) : TAB_W'(1);
        end
        else if (cmd.tab_dec)
        begin
            tab_next = tab_reg - TAB_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            cnt_reg  <= '0;
            tab_reg  <= TAB_W'(1);
            done_reg <= 1'b0;
            fg_reg   <= tts_pkg::RESET_FG;
            bg_reg   <= tts_pkg::RESET_BG;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            tab_reg  <= tab_next;
            done_reg <= cmd.finish;
            if (cfg_valid && (cfg_index == tts_pkg::REG_DEFAULT_FG))
            begin
                fg_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == tts_pkg::REG_DEFAULT_BG))
            begin
                bg_reg <= cfg_data;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.finish)
        begin
            result_reg.cursor_index <= IDX_W'(cur_addr);
            if (read_hit)
            begin
                result_reg.cell_char <= rd_data_reg.ch;
                result_reg.cell_fg   <= rd_data_reg.fg;
                result_reg.cell_bg   <= rd_data_reg.bg;
            end
            else
            begin
                result_reg.cell_char <= '0;
                result_reg.cell_fg   <= '0;
                result_reg.cell_bg   <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/text_terminal_cursor_scroll.sv -----
// top level of the text terminal screen engine
// depends on tts_pkg, tts_ctrl, tts_dp
//
// An item is taken at a rising edge with start high and busy low. Each item
// gives exactly one result, shown on result for one cycle with done high;
// the receiver cannot stall it, so it must take it in that cycle. A new item
// is taken only once the last one has given its result. The cell memory has
// a single write port, so an item writes its cells one at a time: a plain
// character writes one cell, a tab TAB_SPACES spaces, and a backspace blanks
// the cell under the cursor, steps back and blanks the cell it lands on.
// A newline or a character wrap on the last row scrolls the screen up and
// blanks the last row; a clear fills every cell with blanks. After reset busy
// stays high while the memory is filled with blanks.
// Configuration writes are taken in every cycle (cfg_ready is always high)
// but are meant to be issued only while busy is low.
`default_nettype none

module text_terminal_cursor_scroll #(
    parameter int ROWS       = tts_pkg::ROWS_DEF,
    parameter int COLS       = tts_pkg::COLS_DEF,
    parameter int TAB_SPACES = tts_pkg::TAB_SPACES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire tts_pkg::in_item_t                 item,
    output logic                                   done,
    output tts_pkg::out_item_t                     result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tts_pkg::dp_cmd_t  cmd;
    tts_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    tts_dp #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .TAB_SPACES (TAB_SPACES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire
